### rtl/v6trie_pkg.sv
// ----------------------------------------------------------------------------
// v6trie_pkg
// Shared types and codes for the IPv6 binary trie prefix matcher: request and
// result payloads, opcodes, and the controller/datapath command and status.
// ----------------------------------------------------------------------------
package v6trie_pkg;

  localparam int unsigned OPC_W = 2;
  localparam int unsigned HALF_W = 64;
  localparam int unsigned FULL_ADDR_W = 128;
  localparam int unsigned LEN_W = 8;
  localparam int unsigned ENTRY_W = 16;

  localparam logic [OPC_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPC_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OPC_W-1:0] OP_QUERY  = 2'd2;

  typedef struct packed {
    logic [OPC_W-1:0]   opcode;
    logic [HALF_W-1:0]  addr_hi;
    logic [HALF_W-1:0]  addr_lo;
    logic [LEN_W-1:0]   prefix_len;
    logic [ENTRY_W-1:0] entry_value;
  } req_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] match_value;
    logic [LEN_W-1:0]   match_len;
    logic               path_stored;
    logic               table_full;
  } rsp_t;

  typedef struct packed {
    logic init;
    logic load;
    logic read;
    logic eval;
    logic step;
    logic link;
    logic alloc;
    logic store;
    logic set_full;
    logic miss;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic [OPC_W-1:0] op;
    logic             rem_zero;
    logic             child_nil;
    logic             pool_full;
  } status_t;

endpackage

### rtl/v6trie_ram.sv
// ----------------------------------------------------------------------------
// v6trie_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module v6trie_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/v6trie_dpath.sv
// ----------------------------------------------------------------------------
// v6trie_dpath
// Trie datapath: node and value memories, walk registers, free pointer and
// result registers. Acts on commands from the controller.
// ----------------------------------------------------------------------------
module v6trie_dpath #(
  parameter int unsigned NODE_COUNT = 4096,
  parameter int unsigned VALUE_BITS = 16,
  parameter int unsigned ADDR_BITS  = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  v6trie_pkg::req_t   req_i,
  input  v6trie_pkg::cmd_t   cmd_i,
  output v6trie_pkg::status_t status_o,
  output v6trie_pkg::rsp_t   result_o,
  output logic               done_o
);
  import v6trie_pkg::*;

  localparam int unsigned IDX_W  = $clog2(NODE_COUNT);
  localparam int unsigned FREE_W = $clog2(NODE_COUNT + 1);
  localparam int unsigned ROW_W  = 2 * IDX_W + 1;
  localparam int unsigned EXT_W  = (VALUE_BITS > ENTRY_W) ? VALUE_BITS : ENTRY_W;

  logic [OPC_W-1:0]      op_q, op_d;
  logic [ADDR_BITS-1:0]  addr_q, addr_d;
  logic [LEN_W-1:0]      rem_q, rem_d;
  logic [LEN_W-1:0]      depth_q, depth_d;
  logic [IDX_W-1:0]      node_q, node_d;
  logic [FREE_W-1:0]     free_q, free_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [ENTRY_W-1:0]    mval_q, mval_d;
  logic [LEN_W-1:0]      mlen_q, mlen_d;
  logic                  stored_q, stored_d;
  logic                  full_q, full_d;
  logic                  done_q;

  logic [FULL_ADDR_W-1:0] req_addr;
  logic [LEN_W-1:0]       req_len;
  logic [EXT_W-1:0]       entry_ext;
  logic [EXT_W-1:0]       rd_val_ext;

  logic                  node_we, node_re;
  logic [IDX_W-1:0]      node_waddr, node_raddr;
  logic [ROW_W-1:0]      node_wdata, row_rd;
  logic                  val_we;
  logic [VALUE_BITS-1:0] val_rd;

  logic             row_has;
  logic [IDX_W-1:0] c0, c1, child, free_idx;
  logic             cur_bit;

  assign req_addr  = {req_i.addr_hi, req_i.addr_lo};
  assign req_len   = (req_i.prefix_len > LEN_W'(ADDR_BITS)) ? LEN_W'(ADDR_BITS)
                                                            : req_i.prefix_len;
  assign entry_ext = EXT_W'(req_i.entry_value);
  assign rd_val_ext = EXT_W'(val_rd);

  assign row_has  = row_rd[ROW_W-1];
  assign c1       = row_rd[2*IDX_W-1:IDX_W];
  assign c0       = row_rd[IDX_W-1:0];
  assign cur_bit  = addr_q[ADDR_BITS-1];
  assign child    = cur_bit ? c1 : c0;
  assign free_idx = free_q[IDX_W-1:0];

  assign status_o.op        = op_q;
  assign status_o.rem_zero  = (rem_q == '0);
  assign status_o.child_nil = (child == '0);
  assign status_o.pool_full = (free_q == FREE_W'(NODE_COUNT));

  always_comb begin
    node_we    = 1'b0;
    node_waddr = node_q;
    node_wdata = row_rd;
    if (cmd_i.init) begin
      node_we    = 1'b1;
      node_waddr = '0;
      node_wdata = '0;
    end else if (cmd_i.link) begin
      node_we    = 1'b1;
      node_wdata = cur_bit ? {row_has, free_idx, c0} : {row_has, c1, free_idx};
    end else if (cmd_i.alloc) begin
      node_we    = 1'b1;
      node_waddr = free_idx;
      node_wdata = '0;
    end else if (cmd_i.store) begin
      node_we    = 1'b1;
      node_wdata = {1'b1, c1, c0};
    end
  end

  assign val_we     = cmd_i.store;
  assign node_re    = cmd_i.load | cmd_i.read | cmd_i.step;
  assign node_raddr = cmd_i.load ? '0 : (cmd_i.step ? child : node_q);

  v6trie_ram #(
    .WIDTH(ROW_W),
    .DEPTH(NODE_COUNT)
  ) u_node_ram (
    .clk_i  (clk_i),
    .we_i   (node_we),
    .waddr_i(node_waddr),
    .wdata_i(node_wdata),
    .re_i   (node_re),
    .raddr_i(node_raddr),
    .rdata_o(row_rd)
  );

  v6trie_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(NODE_COUNT)
  ) u_value_ram (
    .clk_i  (clk_i),
    .we_i   (val_we),
    .waddr_i(node_q),
    .wdata_i(val_q),
    .re_i   (node_re),
    .raddr_i(node_raddr),
    .rdata_o(val_rd)
  );

  always_comb begin
    op_d     = op_q;
    addr_d   = addr_q;
    rem_d    = rem_q;
    depth_d  = depth_q;
    node_d   = node_q;
    free_d   = free_q;
    val_d    = val_q;
    mval_d   = mval_q;
    mlen_d   = mlen_q;
    stored_d = stored_q;
    full_d   = full_q;
    if (cmd_i.load) begin
      op_d     = req_i.opcode;
      addr_d   = req_addr[ADDR_BITS-1:0];
      rem_d    = req_len;
      depth_d  = '0;
      node_d   = '0;
      val_d    = entry_ext[VALUE_BITS-1:0];
      mval_d   = '0;
      mlen_d   = '0;
      stored_d = (req_i.opcode == OP_QUERY);
      full_d   = 1'b0;
    end
    if (cmd_i.eval && op_q == OP_LOOKUP && depth_q != '0 && row_has) begin
      mval_d = rd_val_ext[ENTRY_W-1:0];
      mlen_d = depth_q;
    end
    if (cmd_i.step || cmd_i.alloc) begin
      addr_d  = {addr_q[ADDR_BITS-2:0], 1'b0};
      rem_d   = rem_q - LEN_W'(1);
      depth_d = depth_q + LEN_W'(1);
      node_d  = cmd_i.step ? child : free_idx;
    end
    if (cmd_i.alloc) begin
      free_d = free_q + FREE_W'(1);
    end
    if (cmd_i.set_full) begin
      full_d = 1'b1;
    end
    if (cmd_i.miss) begin
      stored_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q <= FREE_W'(1);
      done_q <= 1'b0;
    end else begin
      free_q <= free_d;
      done_q <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    addr_q   <= addr_d;
    rem_q    <= rem_d;
    depth_q  <= depth_d;
    node_q   <= node_d;
    val_q    <= val_d;
    mval_q   <= mval_d;
    mlen_q   <= mlen_d;
    stored_q <= stored_d;
    full_q   <= full_d;
  end

  assign result_o.match_value = mval_q;
  assign result_o.match_len   = mlen_q;
  assign result_o.path_stored = stored_q;
  assign result_o.table_full  = full_q;
  assign done_o               = done_q;

endmodule

### rtl/v6trie_ctrl.sv
// ----------------------------------------------------------------------------
// v6trie_ctrl
// Trie walk controller: root clear after reset, request intake, per-level
// walk decisions and node allocation sequencing.
// ----------------------------------------------------------------------------
module v6trie_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  v6trie_pkg::status_t status_i,
  output v6trie_pkg::cmd_t    cmd_o,
  output logic                busy_o
);
  import v6trie_pkg::*;

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_ALLOC = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        case (status_i.op)
          OP_INSERT: begin
            if (status_i.rem_zero) begin
              cmd_o.store  = 1'b1;
              cmd_o.finish = 1'b1;
              state_d      = S_IDLE;
            end else if (!status_i.child_nil) begin
              cmd_o.step = 1'b1;
            end else if (status_i.pool_full) begin
              cmd_o.set_full = 1'b1;
              cmd_o.finish   = 1'b1;
              state_d        = S_IDLE;
            end else begin
              cmd_o.link = 1'b1;
              state_d    = S_ALLOC;
            end
          end
          OP_LOOKUP: begin
            if (status_i.rem_zero || status_i.child_nil) begin
              cmd_o.finish = 1'b1;
              state_d      = S_IDLE;
            end else begin
              cmd_o.step = 1'b1;
            end
          end
          OP_QUERY: begin
            if (status_i.rem_zero) begin
              cmd_o.finish = 1'b1;
              state_d      = S_IDLE;
            end else if (status_i.child_nil) begin
              cmd_o.miss   = 1'b1;
              cmd_o.finish = 1'b1;
              state_d      = S_IDLE;
            end else begin
              cmd_o.step = 1'b1;
            end
          end
          default: begin
            cmd_o.finish = 1'b1;
            state_d      = S_IDLE;
          end
        endcase
      end
      S_ALLOC: begin
        cmd_o.alloc = 1'b1;
        state_d     = S_READ;
      end
      S_READ: begin
        cmd_o.read = 1'b1;
        state_d    = S_EVAL;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

### rtl/ipv6_binary_trie_prefix_match.sv
// ----------------------------------------------------------------------------
// ipv6_binary_trie_prefix_match
// Longest prefix match over a binary trie of IPv6 prefixes.
// Per level the walk steps in S_EVAL over an existing node; a new node is
// linked in S_EVAL, allocated in S_ALLOC and read in S_READ before the next
// S_EVAL. done strobes in the first cycle with busy low.
// Throughput: one request at a time, paced by the single node memory read
// per trie level. Results are strobed once and cannot be stalled.
// Reset: free pointer returns to one; busy stays high one cycle to clear root.
// ----------------------------------------------------------------------------
module ipv6_binary_trie_prefix_match #(
  parameter int unsigned NODE_COUNT = 4096,
  parameter int unsigned VALUE_BITS = 16,
  parameter int unsigned ADDR_BITS  = 128
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  v6trie_pkg::req_t req_i,
  output v6trie_pkg::rsp_t result_o,
  output logic             done_o
);
  import v6trie_pkg::*;

  cmd_t    cmd;
  status_t status;

  v6trie_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .status_i(status),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  v6trie_dpath #(
    .NODE_COUNT(NODE_COUNT),
    .VALUE_BITS(VALUE_BITS),
    .ADDR_BITS (ADDR_BITS)
  ) u_dpath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .cmd_i   (cmd),
    .status_o(status),
    .result_o(result_o),
    .done_o  (done_o)
  );

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobed while busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_single_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.match_len != '0) |-> (!result_o.path_stored && !result_o.table_full))
    else $error("lookup result mixed with other fields");

endmodule

### tb/trie_match_checker.sv
// ----------------------------------------------------------------------------
// trie_match_checker
// Watches the request and result channels of the IPv6 trie matcher. For each
// request it walks its own copy of the node table and queues the expected
// result. Each strobed result is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module trie_match_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  v6trie_pkg::req_t   req_i,
  input  v6trie_pkg::rsp_t   result_i,
  input  logic               done_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o,
  output int unsigned        full_seen_o,
  output int unsigned        hit_seen_o
);
  import v6trie_pkg::*;

  localparam int unsigned NODE_COUNT = 4096;
  localparam int unsigned IDX_W = $clog2(NODE_COUNT);
  localparam logic [IDX_W:0] FREE_END = (IDX_W+1)'(NODE_COUNT);

  logic [IDX_W-1:0]   trie_zero [NODE_COUNT];
  logic [IDX_W-1:0]   trie_one  [NODE_COUNT];
  logic [ENTRY_W-1:0] node_val  [NODE_COUNT];
  bit                 node_set  [NODE_COUNT];
  logic [IDX_W:0]     free_node;
  rsp_t               expected_rsp_q [$];
  int unsigned        fails;
  int unsigned        full_seen;
  int unsigned        hit_seen;

  function automatic rsp_t predict_trie_op(input req_t r);
    rsp_t res;
    logic [FULL_ADDR_W-1:0] addr;
    int unsigned depth_lim;
    logic [IDX_W-1:0] node;
    logic [IDX_W-1:0] nxt;
    int unsigned d;
    logic b;
    bit ok;
    res = '0;
    addr = {r.addr_hi, r.addr_lo};
    depth_lim = 32'(r.prefix_len);
    if (depth_lim > FULL_ADDR_W) depth_lim = FULL_ADDR_W;
    node = '0;
    case (r.opcode)
      OP_INSERT: begin
        ok = 1'b1;
        for (d = 0; d < depth_lim; d++) begin
          b = addr[FULL_ADDR_W-1];
          addr = addr << 1;
          nxt = b ? trie_one[node] : trie_zero[node];
          if (nxt == '0) begin
            if (free_node >= FREE_END) begin
              ok = 1'b0;
              break;
            end
            nxt = free_node[IDX_W-1:0];
            free_node = free_node + 1'b1;
            if (b) trie_one[node] = nxt;
            else trie_zero[node] = nxt;
          end
          node = nxt;
        end
        if (ok) begin
          node_val[node] = r.entry_value;
          node_set[node] = 1'b1;
        end else begin
          res.table_full = 1'b1;
        end
      end
      OP_LOOKUP: begin
        for (d = 0; d < depth_lim; d++) begin
          b = addr[FULL_ADDR_W-1];
          addr = addr << 1;
          nxt = b ? trie_one[node] : trie_zero[node];
          if (nxt == '0) break;
          node = nxt;
          if (node_set[node]) begin
            res.match_value = node_val[node];
            res.match_len = LEN_W'(d + 1);
          end
        end
      end
      OP_QUERY: begin
        res.path_stored = 1'b1;
        for (d = 0; d < depth_lim; d++) begin
          b = addr[FULL_ADDR_W-1];
          addr = addr << 1;
          nxt = b ? trie_one[node] : trie_zero[node];
          if (nxt == '0) begin
            res.path_stored = 1'b0;
            break;
          end
          node = nxt;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_field(input string name, input logic [ENTRY_W-1:0] want,
                              input logic [ENTRY_W-1:0] got);
    if (got !== want) begin
      $display("%0t ERROR: %s expected %0h got %0h", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      trie_zero = '{default: '0};
      trie_one = '{default: '0};
      node_val = '{default: '0};
      node_set = '{default: 1'b0};
      free_node = (IDX_W+1)'(1);
      expected_rsp_q.delete();
      fails = 0;
      full_seen = 0;
      hit_seen = 0;
    end else begin
      if (done_i) begin
        if (expected_rsp_q.size() == 0) begin
          $display("%0t ERROR: result %h with no request pending", $time, result_i);
          fails++;
        end else begin
          want = expected_rsp_q.pop_front();
          report_field("match_value", want.match_value, result_i.match_value);
          report_field("match_len", want.match_len, result_i.match_len);
          report_field("path_stored", want.path_stored, result_i.path_stored);
          report_field("table_full", want.table_full, result_i.table_full);
        end
      end
      if (start_i && !busy_i) begin
        want = predict_trie_op(req_i);
        if (want.table_full) full_seen++;
        if (want.match_len != 0) hit_seen++;
        expected_rsp_q = {expected_rsp_q, want};
      end
    end
    pending_o <= expected_rsp_q.size();
    fail_count_o <= fails;
    full_seen_o <= full_seen;
    hit_seen_o <= hit_seen;
  end

endmodule

### tb/tb_ipv6_binary_trie_prefix_match.sv
// ----------------------------------------------------------------------------
// tb_ipv6_binary_trie_prefix_match
// Drives inserts, lookups and path queries into the trie matcher in bursts
// with random gaps: a directed set of edge cases, then random prefixes that
// mostly share a few base addresses, with some long random inserts to
// exhaust the node table. A checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module tb_ipv6_binary_trie_prefix_match;
  import v6trie_pkg::*;

  localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned RANDOM_COUNT = 1380;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 400;
  localparam logic [FULL_ADDR_W-1:0] ONES = '1;
  localparam logic [FULL_ADDR_W-1:0] ZEROS = '0;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic done;
  req_t req = '0;
  rsp_t rsp;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned full_seen;
  int unsigned hit_seen;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned n_insert = 0;
  int unsigned n_lookup = 0;
  int unsigned n_query = 0;
  int unsigned n_unused = 0;
  logic [FULL_ADDR_W-1:0] prefix_pool [8];

  ipv6_binary_trie_prefix_match dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .req_i    (req),
    .result_o (rsp),
    .done_o   (done)
  );

  trie_match_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req),
    .result_i     (rsp),
    .done_i       (done),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .full_seen_o  (full_seen),
    .hit_seen_o   (hit_seen)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t ERROR: no request or result for %0d cycles", $time, IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic req_t request(input logic [OPC_W-1:0] op,
                                   input logic [FULL_ADDR_W-1:0] addr,
                                   input logic [LEN_W-1:0] len,
                                   input logic [ENTRY_W-1:0] val);
    req_t r;
    r.opcode = op;
    r.addr_hi = addr[FULL_ADDR_W-1:HALF_W];
    r.addr_lo = addr[HALF_W-1:0];
    r.prefix_len = len;
    r.entry_value = val;
    return r;
  endfunction

  function automatic req_t random_request();
    int unsigned sel;
    int unsigned keep;
    logic [OPC_W-1:0] op;
    logic [LEN_W-1:0] len;
    logic [FULL_ADDR_W-1:0] addr;
    logic [FULL_ADDR_W-1:0] noise;
    logic [FULL_ADDR_W-1:0] mask;
    sel = $urandom_range(0, 99);
    if (sel < 40) op = OP_INSERT;
    else if (sel < 75) op = OP_LOOKUP;
    else if (sel < 97) op = OP_QUERY;
    else op = OP_UNUSED;
    sel = $urandom_range(0, 99);
    if (sel < 5) len = '0;
    else if (sel < 50) len = LEN_W'($urandom_range(1, 24));
    else if (sel < 75) len = LEN_W'($urandom_range(25, 64));
    else if (sel < 93) len = LEN_W'($urandom_range(65, 128));
    else len = LEN_W'($urandom_range(129, 255));
    noise = {$urandom(), $urandom(), $urandom(), $urandom()};
    if (op == OP_INSERT && $urandom_range(0, 7) == 0) begin
      addr = noise;
      len = LEN_W'(FULL_ADDR_W);
    end else begin
      keep = $urandom_range(0, FULL_ADDR_W);
      mask = ONES >> keep;
      addr = (prefix_pool[3'($urandom_range(0, 7))] & ~mask) | (noise & mask);
    end
    return request(op, addr, len, ENTRY_W'($urandom_range(0, 65535)));
  endfunction

  task automatic push_request(input req_t r);
    int unsigned gap;
    start <= 1'b1;
    req <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    case (r.opcode)
      OP_INSERT: n_insert++;
      OP_LOOKUP: n_lookup++;
      OP_QUERY:  n_query++;
      default:   n_unused++;
    endcase
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 8);
      gap = $urandom_range(1, 20);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end else begin
      burst_left--;
    end
  endtask

  initial begin
    prefix_pool[0] = ONES;
    prefix_pool[1] = ZEROS;
    for (int i = 2; i < 8; i++) begin
      prefix_pool[3'(i)] = {$urandom(), $urandom(), $urandom(), $urandom()};
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_request(request(OP_LOOKUP, ONES, 8'd128, 16'h0000));
    push_request(request(OP_QUERY, ZEROS, 8'd0, 16'h0000));
    push_request(request(OP_QUERY, ONES, 8'd1, 16'h0000));
    push_request(request(OP_INSERT, ZEROS, 8'd0, 16'hABCD));
    push_request(request(OP_LOOKUP, ZEROS, 8'd128, 16'h0000));
    push_request(request(OP_INSERT, ONES, 8'd128, 16'hFFFF));
    push_request(request(OP_LOOKUP, ONES, 8'd128, 16'h0000));
    push_request(request(OP_LOOKUP, ONES, 8'd255, 16'h0000));
    push_request(request(OP_INSERT, ONES, 8'd1, 16'h0001));
    push_request(request(OP_LOOKUP, ONES, 8'd64, 16'h0000));
    push_request(request(OP_INSERT, ONES, 8'd1, 16'h8000));
    push_request(request(OP_LOOKUP, ONES, 8'd100, 16'h0000));
    push_request(request(OP_INSERT, ZEROS, 8'd128, 16'h0000));
    push_request(request(OP_LOOKUP, ZEROS, 8'd128, 16'h0000));
    push_request(request(OP_QUERY, ONES, 8'd128, 16'h0000));
    push_request(request(OP_QUERY, ONES ^ 128'd1, 8'd128, 16'h0000));
    push_request(request(OP_QUERY, ONES, 8'd200, 16'h0000));
    push_request(request(OP_LOOKUP, ONES ^ 128'd1, 8'd128, 16'h0000));
    push_request(request(OP_UNUSED, ONES, 8'd255, 16'hFFFF));
    push_request(request(OP_INSERT, {64'h8000_0000_0000_0000, 64'd1}, 8'd255, 16'h1234));
    push_request(request(OP_LOOKUP, {64'h8000_0000_0000_0000, 64'd1}, 8'd128, 16'h0000));
    push_request(request(OP_LOOKUP, ONES, 8'd0, 16'h0000));
    push_request(request(OP_QUERY, ZEROS, 8'd129, 16'h0000));

    for (int i = 0; i < RANDOM_COUNT; i++) begin
      push_request(random_request());
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests: %0d inserts, %0d lookups, %0d path queries, %0d unused",
             n_insert + n_lookup + n_query + n_unused, n_insert, n_lookup, n_query, n_unused);
    $display("%0d lookups found a prefix, %0d inserts ran out of nodes", hit_seen, full_seen);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
